// ----- sv/scic_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scic_pkg
// Shared types and constants for the sample chunk inlet checker.
// ----------------------------------------------------------------------------
package scic_pkg;

  localparam int MSG_HDR_BYTES_DEF   = 8;
  localparam int CFG_HDR_BYTES_DEF   = 4;
  localparam int CHUNK_HDR_BYTES_DEF = 4;

  localparam int DIVIDEND_W = 16;
  localparam int DIVISOR_W  = 8;
  localparam int DIV_CNT_W  = 4;
  localparam int OFS_W      = 11;

  localparam logic [7:0]  CT_VOID     = 8'd0;
  localparam logic [7:0]  CT_WAVE     = 8'd1;
  localparam logic [7:0]  VER_MASK    = 8'h30;
  localparam logic [23:0] MIN_DUR     = 24'd200;
  localparam logic [3:0]  ERR_LIMIT   = 4'd10;

  typedef enum logic [3:0] {
    ST_VOID  = 4'd0,
    ST_FWD   = 4'd1,
    ST_CFG   = 4'd2,
    ST_LEN   = 4'd3,
    ST_VER   = 4'd4,
    ST_SHORT = 4'd5,
    ST_PAST  = 4'd6,
    ST_SKIP  = 4'd7,
    ST_TYPE  = 4'd8
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- sv/scic_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scic_div
// Serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module scic_div
  import scic_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output div_stat_t             stat,
  output logic [DIVIDEND_W-1:0] quotient,
  output logic [DIVISOR_W-1:0]  remainder
);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [DIVISOR_W-1:0]  dvs_r, dvs_nxt;
  logic [DIVISOR_W:0]    trial;
  logic                  fits;

  always_comb begin
    trial    = {rem_r, quo_r[DIVIDEND_W-1]};
    fits     = trial >= {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? DIVISOR_W'(trial - {1'b0, dvs_r}) : trial[DIVISOR_W-1:0];
      quo_nxt = {quo_r[DIVIDEND_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == {DIV_CNT_W{1'b1}}) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ----- sv/sample_chunk_inlet_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_chunk_inlet_checker
// Checks one channel message summary per transaction and gives one verdict.
// Wave chunks pass through setup, the serial divider steps, the divider done
// pulse and finish; other chunk types and early errors skip the divider.
// Only one transaction is in the sequencer at a time, held by the serial
// divider; a new input is taken while the previous result awaits out_ready.
// Reset: synchronous, active low; clears chronology state and the sequencer.
// ----------------------------------------------------------------------------
module sample_chunk_inlet_checker
  import scic_pkg::*;
#(
  parameter int MSG_HDR_BYTES   = MSG_HDR_BYTES_DEF,
  parameter int CFG_HDR_BYTES   = CFG_HDR_BYTES_DEF,
  parameter int CHUNK_HDR_BYTES = CHUNK_HDR_BYTES_DEF
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_chunk_type,
  input  logic        in_config_present,
  input  logic [7:0]  in_config_word_count,
  input  logic [15:0] in_message_length,
  input  logic [7:0]  in_chunk_flags,
  input  logic [23:0] in_chunk_duration,
  input  logic [31:0] in_msg_timestamp,
  input  logic        in_config_ok,
  input  logic [7:0]  in_config_flags,
  input  logic [7:0]  in_sample_size,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_status,
  output logic        out_forward,
  output logic [15:0] out_sample_count,
  output logic [10:0] out_data_offset,
  output logic [15:0] out_data_length,
  output logic [7:0]  out_flags,
  output logic [23:0] out_duration,
  output logic        out_invalidate_config
);

  localparam logic [OFS_W-1:0] BASE_OFS = OFS_W'(MSG_HDR_BYTES + CHUNK_HDR_BYTES);
  localparam logic [OFS_W-1:0] CFG_OFS  = OFS_W'(CFG_HDR_BYTES);

  state_t state_r, state_nxt;

  // latched transaction
  logic [7:0]  type_r;
  logic        cfg_present_r;
  logic [7:0]  words_r;
  logic [15:0] mlen_r;
  logic [7:0]  cflags_r;
  logic [23:0] dur_r;
  logic [31:0] ts_r;
  logic        cfg_ok_r;
  logic [7:0]  cfg_flags_r;
  logic [7:0]  ssize_r;

  logic [OFS_W-1:0] offset_r, offset_nxt;
  logic [15:0]      plen_r, plen_nxt;
  logic             len_bad_r, len_bad_nxt;

  // chronology
  logic        chron_valid_r, chron_valid_nxt;
  logic [31:0] exp_time_r, exp_time_nxt;
  logic [3:0]  err_cnt_r, err_cnt_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [3:0]  o_status_r;
  logic        o_fwd_r;
  logic [15:0] o_count_r;
  logic [10:0] o_ofs_r;
  logic [15:0] o_len_r;
  logic [7:0]  o_flags_r;
  logic [23:0] o_dur_r;
  logic        o_inv_r;

  logic        accept;
  logic        need_div;
  logic        div_start;
  logic        load;
  div_stat_t   div_stat;
  logic [15:0] quo;
  logic [7:0]  rem;

  status_t     fin_status;
  logic        fin_fwd;
  logic        fin_inv;
  logic [31:0] diff;
  logic [3:0]  err_inc;

  scic_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (plen_nxt),
    .divisor   (ssize_r),
    .stat      (div_stat),
    .quotient  (quo),
    .remainder (rem)
  );

  assign accept   = in_valid && in_ready;
  assign load     = (state_r == S_DONE) && (out_ready || !out_valid_r);
  assign need_div = (type_r == CT_WAVE) && cfg_ok_r && !len_bad_nxt;

  // setup: offset, payload length and early length and sample size check
  always_comb begin
    offset_nxt = BASE_OFS;
    if (cfg_present_r) begin
      offset_nxt = BASE_OFS + CFG_OFS + {1'b0, words_r, 2'b00};
    end
    len_bad_nxt = (mlen_r < {5'b0, offset_nxt}) || (ssize_r == 8'd0);
    plen_nxt    = mlen_r - {5'b0, offset_nxt};
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        state_nxt = need_div ? S_DIV : S_DONE;
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    case (state_r)
      S_IDLE:  in_ready  = 1'b1;
      S_PREP:  div_start = need_div;
      default: ;
    endcase
  end

  // verdict and chronology update
  always_comb begin
    fin_status      = ST_FWD;
    fin_fwd         = 1'b0;
    fin_inv         = 1'b0;
    err_inc         = 4'd0;
    chron_valid_nxt = chron_valid_r;
    exp_time_nxt    = exp_time_r;
    diff            = ts_r - exp_time_r;
    if (type_r == CT_VOID) begin
      fin_status = ST_VOID;
    end else if (type_r != CT_WAVE) begin
      fin_status = ST_TYPE;
    end else if (!cfg_ok_r) begin
      fin_status = ST_CFG;
    end else if (len_bad_r || rem != 8'd0) begin
      fin_status = ST_LEN;
    end else if ((cflags_r & VER_MASK) != (cfg_flags_r & VER_MASK)) begin
      fin_status = ST_VER;
    end else if (quo == 16'd0 || dur_r < MIN_DUR) begin
      fin_status = ST_SHORT;
    end else begin
      exp_time_nxt    = ts_r + {8'd0, dur_r};
      chron_valid_nxt = 1'b1;
      fin_fwd         = 1'b1;
      if (chron_valid_r) begin
        if (diff[31]) begin
          fin_status = ST_PAST;
          fin_fwd    = 1'b0;
          err_inc    = 4'd1;
        end else if (diff != 32'd0) begin
          fin_status = ST_SKIP;
          err_inc    = 4'd1;
        end
      end
    end
    err_cnt_nxt = err_cnt_r + err_inc;
    if (err_cnt_nxt > ERR_LIMIT) begin
      fin_inv         = 1'b1;
      err_cnt_nxt     = 4'd0;
      chron_valid_nxt = 1'b0;
      exp_time_nxt    = 32'd0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      chron_valid_r <= 1'b0;
      exp_time_r    <= 32'd0;
      err_cnt_r     <= 4'd0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (load) begin
        chron_valid_r <= chron_valid_nxt;
        exp_time_r    <= exp_time_nxt;
        err_cnt_r     <= err_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      type_r        <= in_chunk_type;
      cfg_present_r <= in_config_present;
      words_r       <= in_config_word_count;
      mlen_r        <= in_message_length;
      cflags_r      <= in_chunk_flags;
      dur_r         <= in_chunk_duration;
      ts_r          <= in_msg_timestamp;
      cfg_ok_r      <= in_config_ok;
      cfg_flags_r   <= in_config_flags;
      ssize_r       <= in_sample_size;
    end
    if (state_r == S_PREP) begin
      offset_r  <= offset_nxt;
      plen_r    <= plen_nxt;
      len_bad_r <= len_bad_nxt;
    end
    if (load) begin
      o_status_r <= fin_status;
      o_fwd_r    <= fin_fwd;
      o_count_r  <= fin_fwd ? quo      : 16'd0;
      o_ofs_r    <= fin_fwd ? offset_r : 11'd0;
      o_len_r    <= fin_fwd ? plen_r   : 16'd0;
      o_flags_r  <= fin_fwd ? cflags_r : 8'd0;
      o_dur_r    <= fin_fwd ? dur_r    : 24'd0;
      o_inv_r    <= fin_inv;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_status            = o_status_r;
  assign out_forward           = o_fwd_r;
  assign out_sample_count      = o_count_r;
  assign out_data_offset       = o_ofs_r;
  assign out_data_length       = o_len_r;
  assign out_flags             = o_flags_r;
  assign out_duration          = o_dur_r;
  assign out_invalidate_config = o_inv_r;

endmodule

// ----- sim/sample_chunk_inlet_checker_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_chunk_inlet_checker_tb
// Feeds channel message summaries through the inlet checker and compares
// every verdict field against a local model of the chunk checks and of the
// chronology tracker. A directed set covers the error paths, the header and
// payload size limits, the timestamp wrap and the error limit. A random set
// follows, made mostly of in-sequence wave chunks with some broken chunks and
// some noise. The sender works in bursts and the receiver stalls in patterns.
// ----------------------------------------------------------------------------
module sample_chunk_inlet_checker_tb;
  import scic_pkg::*;

  typedef struct packed {
    logic [7:0]  chunk_type;
    logic        config_present;
    logic [7:0]  config_word_count;
    logic [15:0] message_length;
    logic [7:0]  chunk_flags;
    logic [23:0] chunk_duration;
    logic [31:0] msg_timestamp;
    logic        config_ok;
    logic [7:0]  config_flags;
    logic [7:0]  sample_size;
  } chunk_t;

  typedef struct packed {
    status_t     status;
    logic        forward;
    logic [15:0] sample_count;
    logic [10:0] data_offset;
    logic [15:0] data_length;
    logic [7:0]  flags;
    logic [23:0] duration;
    logic        invalidate;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  chunk_t      cur = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_status;
  logic        out_forward;
  logic [15:0] out_sample_count;
  logic [10:0] out_data_offset;
  logic [15:0] out_data_length;
  logic [7:0]  out_flags;
  logic [23:0] out_duration;
  logic        out_invalidate_config;

  chunk_t   pending[$];
  verdict_t verdicts[$];
  verdict_t want;
  int       mismatches = 0;

  // chronology tracker copy
  logic        hist_valid = 1'b0;
  logic [31:0] next_time = '0;
  logic [3:0]  late_count = '0;

  // generator's view of the next in-sequence timestamp
  logic [31:0] gen_time;

  int burst_left = 1;
  int gap_left = 0;
  int stall_mode = 0;
  int mode_left = 0;
  int stall_tick = 0;

  sample_chunk_inlet_checker uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_chunk_type        (cur.chunk_type),
    .in_config_present    (cur.config_present),
    .in_config_word_count (cur.config_word_count),
    .in_message_length    (cur.message_length),
    .in_chunk_flags       (cur.chunk_flags),
    .in_chunk_duration    (cur.chunk_duration),
    .in_msg_timestamp     (cur.msg_timestamp),
    .in_config_ok         (cur.config_ok),
    .in_config_flags      (cur.config_flags),
    .in_sample_size       (cur.sample_size),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status           (out_status),
    .out_forward          (out_forward),
    .out_sample_count     (out_sample_count),
    .out_data_offset      (out_data_offset),
    .out_data_length      (out_data_length),
    .out_flags            (out_flags),
    .out_duration         (out_duration),
    .out_invalidate_config(out_invalidate_config)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int unsigned header_bytes(logic cfgp, logic [7:0] wds);
    int unsigned ofs;
    ofs = MSG_HDR_BYTES_DEF + CHUNK_HDR_BYTES_DEF;
    if (cfgp) ofs += CFG_HDR_BYTES_DEF + 4 * wds;
    return ofs;
  endfunction

  // verdict for one chunk; advances the chronology tracker
  function automatic verdict_t judge_chunk(input chunk_t c);
    verdict_t    r;
    int unsigned ofs;
    int unsigned plen;
    int unsigned cnt;
    logic [31:0] diff;
    r = verdict_t'('0);
    r.status = ST_VOID;
    if (c.chunk_type == CT_VOID) begin
      r.status = ST_VOID;
    end else if (c.chunk_type != CT_WAVE) begin
      r.status = ST_TYPE;
    end else if (!c.config_ok) begin
      r.status = ST_CFG;
    end else begin
      ofs = header_bytes(c.config_present, c.config_word_count);
      if (c.message_length < ofs || c.sample_size == 0) begin
        r.status = ST_LEN;
      end else begin
        plen = c.message_length - ofs;
        cnt = plen / c.sample_size;
        if ((plen % c.sample_size) != 0) begin
          r.status = ST_LEN;
        end else if ((c.chunk_flags & VER_MASK) != (c.config_flags & VER_MASK)) begin
          r.status = ST_VER;
        end else if (cnt < 1 || c.chunk_duration < MIN_DUR) begin
          r.status = ST_SHORT;
        end else begin
          r.status = ST_FWD;
          if (hist_valid) begin
            diff = c.msg_timestamp - next_time;
            if (diff[31]) begin
              late_count++;
              r.status = ST_PAST;
            end else if (diff != 0) begin
              late_count++;
              r.status = ST_SKIP;
            end
          end
          hist_valid = 1'b1;
          next_time = c.msg_timestamp + c.chunk_duration;
          if (r.status != ST_PAST) begin
            r.forward = 1'b1;
            r.sample_count = cnt[15:0];
            r.data_offset = ofs[10:0];
            r.data_length = plen[15:0];
            r.flags = c.chunk_flags;
            r.duration = c.chunk_duration;
          end
        end
      end
    end
    if (late_count > ERR_LIMIT) begin
      hist_valid = 1'b0;
      next_time = '0;
      late_count = '0;
      r.invalidate = 1'b1;
    end
    return r;
  endfunction

  // well-formed wave chunk with matching version bits
  function automatic chunk_t make_wave(logic [31:0] ts, logic [23:0] dur, int unsigned cnt,
                                       logic [7:0] ssz, logic cfgp, logic [7:0] wds);
    chunk_t c;
    c.chunk_type = CT_WAVE;
    c.config_present = cfgp;
    c.config_word_count = wds;
    c.message_length = 16'(header_bytes(cfgp, wds) + cnt * ssz);
    c.chunk_flags = 8'($urandom);
    c.chunk_duration = dur;
    c.msg_timestamp = ts;
    c.config_ok = 1'b1;
    c.config_flags = (8'($urandom) & ~VER_MASK) | (c.chunk_flags & VER_MASK);
    c.sample_size = ssz;
    return c;
  endfunction

  task automatic queue_chunk(input chunk_t c, input bit in_seq);
    pending.push_back(c);
    if (in_seq) gen_time = c.msg_timestamp + c.chunk_duration;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) verdicts.push_back(judge_chunk(cur));
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending.size() != 0) begin
          cur <= pending.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left <= $urandom_range(50, 400);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) == 0);
      2: out_ready <= ($urandom_range(0, 1) == 1);
      default: out_ready <= ((stall_tick % 9) < 4);
    endcase
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (verdicts.size() == 0) begin
        $error("unexpected transaction: status %0d", out_status);
        mismatches++;
      end else begin
        want = verdicts.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_status);
          mismatches++;
        end
        if (out_forward !== want.forward) begin
          $error("forward: expected %0d, actual %0d", want.forward, out_forward);
          mismatches++;
        end
        if (out_sample_count !== want.sample_count) begin
          $error("sample_count: expected %0d, actual %0d", want.sample_count,
                 out_sample_count);
          mismatches++;
        end
        if (out_data_offset !== want.data_offset) begin
          $error("data_offset: expected %0d, actual %0d", want.data_offset, out_data_offset);
          mismatches++;
        end
        if (out_data_length !== want.data_length) begin
          $error("data_length: expected %0d, actual %0d", want.data_length, out_data_length);
          mismatches++;
        end
        if (out_flags !== want.flags) begin
          $error("out_flags: expected %0h, actual %0h", want.flags, out_flags);
          mismatches++;
        end
        if (out_duration !== want.duration) begin
          $error("out_duration: expected %0d, actual %0d", want.duration, out_duration);
          mismatches++;
        end
        if (out_invalidate_config !== want.invalidate) begin
          $error("invalidate_config: expected %0d, actual %0d", want.invalidate,
                 out_invalidate_config);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    chunk_t      c;
    int          n;
    int          pick;
    int          sel;
    logic [7:0]  ssz;
    logic        cfgp;
    logic [7:0]  wds;
    int unsigned ofs;
    int unsigned room;
    int unsigned cnt;
    logic [23:0] dur;
    logic [31:0] ts;

    gen_time = $urandom;

    // directed: non-wave types and each early rejection
    c = make_wave(gen_time, 1000, 4, 4, 1'b1, 8'd3);
    c.chunk_type = CT_VOID;
    queue_chunk(c, 0);
    c.chunk_type = 8'd2;
    queue_chunk(c, 0);
    c.chunk_type = 8'hFF;
    queue_chunk(c, 0);
    c = make_wave(gen_time, 1000, 4, 4, 1'b0, 8'd0);
    c.config_ok = 1'b0;
    queue_chunk(c, 0);
    c = make_wave(gen_time, 1000, 4, 4, 1'b0, 8'd0);
    c.message_length = 16'd0;
    queue_chunk(c, 0);
    c = make_wave(gen_time, 1000, 4, 4, 1'b1, 8'hFF);
    c.message_length = 16'(header_bytes(1'b1, 8'hFF) - 1);
    queue_chunk(c, 0);
    c = make_wave(gen_time, 1000, 4, 4, 1'b0, 8'd0);
    c.sample_size = 8'd0;
    queue_chunk(c, 0);
    c = make_wave(gen_time, 1000, 3, 4, 1'b1, 8'd1);
    c.message_length = c.message_length + 16'd1;
    queue_chunk(c, 0);
    c = make_wave(gen_time, 1000, 3, 4, 1'b0, 8'd0);
    c.config_flags = c.config_flags ^ 8'h10;
    queue_chunk(c, 0);
    c.config_flags = c.config_flags ^ 8'h30;
    queue_chunk(c, 0);
    queue_chunk(make_wave(gen_time, 1000, 0, 4, 1'b0, 8'd0), 0);
    queue_chunk(make_wave(gen_time, 199, 2, 4, 1'b0, 8'd0), 0);

    // directed: first chunk starts the chronology, then size extremes
    queue_chunk(make_wave(gen_time, 200, 1, 1, 1'b0, 8'd0), 1);
    queue_chunk(make_wave(gen_time, 24'hFFFFFF, 256, 8'hFF, 1'b0, 8'd0), 1);
    queue_chunk(make_wave(gen_time, 500, 65519, 8'd1, 1'b0, 8'd0), 1);

    // directed: jump near the top of the time range, then in sequence across the wrap
    queue_chunk(make_wave(32'hFFFF_FF00, 1000, 2, 2, 1'b1, 8'd0), 1);
    queue_chunk(make_wave(gen_time, 300, 2, 2, 1'b1, 8'd0), 1);

    // directed: past and skip, sign boundary of the difference, error limit
    queue_chunk(make_wave(gen_time - 1, 300, 1, 3, 1'b0, 8'd0), 1);
    queue_chunk(make_wave(gen_time + 1, 300, 1, 3, 1'b0, 8'd0), 1);
    queue_chunk(make_wave(gen_time + 32'h7FFF_FFFF, 300, 1, 3, 1'b0, 8'd0), 1);
    queue_chunk(make_wave(gen_time + 32'h8000_0000, 300, 1, 3, 1'b0, 8'd0), 1);
    for (n = 0; n < 6; n++) begin
      ts = (n % 2) ? gen_time + 7 : gen_time - 7;
      queue_chunk(make_wave(ts, 400, 2, 5, 1'b0, 8'd0), 1);
    end
    queue_chunk(make_wave(gen_time, 400, 2, 5, 1'b0, 8'd0), 1);

    // random
    for (n = 0; n < 1550; n++) begin
      pick = $urandom_range(0, 99);
      ssz = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 255)) :
            8'($urandom_range(1, 16));
      cfgp = 1'($urandom_range(0, 1));
      wds = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) :
            8'($urandom_range(0, 8));
      ofs = header_bytes(cfgp, wds);
      room = (65535 - ofs) / ssz;
      cnt = ($urandom_range(0, 19) == 0) ? $urandom_range(1, room) :
            $urandom_range(1, (room < 16) ? room : 16);
      dur = ($urandom_range(0, 9) == 0) ? 24'($urandom_range(200, 24'hFFFFFF)) :
            24'($urandom_range(200, 5000));
      sel = $urandom_range(0, 39);
      if (sel < 33) ts = gen_time;
      else if (sel < 36) ts = gen_time + $urandom_range(1, 1000);
      else if (sel < 39) ts = gen_time - $urandom_range(1, 1000);
      else ts = $urandom;
      c = make_wave(ts, dur, cnt, ssz, cfgp, wds);
      if (pick < 65) begin
        queue_chunk(c, 1);
      end else if (pick < 80) begin
        case ($urandom_range(0, 5))
          0: c.config_ok = 1'b0;
          1: c.message_length = 16'($urandom_range(0, ofs - 1));
          2: c.message_length = (ssz > 1) ? c.message_length - 16'd1 : 16'(ofs - 1);
          3: c.config_flags = c.config_flags ^ (8'h10 << $urandom_range(0, 1));
          4: c.chunk_duration = 24'($urandom_range(0, 199));
          default: c.message_length = 16'(ofs);
        endcase
        queue_chunk(c, 0);
      end else begin
        case ($urandom_range(0, 2))
          0: c.chunk_type = CT_VOID;
          1: c.chunk_type = CT_WAVE;
          default: c.chunk_type = 8'($urandom);
        endcase
        c.config_present = 1'($urandom_range(0, 1));
        c.config_word_count = 8'($urandom);
        c.message_length = 16'($urandom);
        c.chunk_flags = 8'($urandom);
        c.chunk_duration = 24'($urandom);
        c.msg_timestamp = $urandom;
        c.config_ok = 1'($urandom_range(0, 1));
        c.config_flags = 8'($urandom);
        c.sample_size = 8'($urandom_range(1, 255));
        queue_chunk(c, 0);
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (pending.size() != 0 || in_valid) @(posedge clk);
    while (verdicts.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    if (mismatches == 0 && verdicts.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- sample_chunk_inlet_checker.f -----
sv/scic_pkg.sv
sv/scic_div.sv
sv/sample_chunk_inlet_checker.sv
sim/sample_chunk_inlet_checker_tb.sv
